// ----- rtl/trli_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trli_pkg: shared definitions of the table row linear interpolator
// Widths, request opcodes, result case codes and fixed constants.
// ---------------------------------------------------------------------------
package trli_pkg;

    localparam int MAX_AGES = 16;
    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 16;

    localparam int AGE_W  = $clog2(MAX_AGES);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = AGE_W + ROW_W + COL_W;
    localparam int CNT_W  = ROW_W + 1;

    typedef logic [1:0] t_op;
    localparam t_op OP_WORD  = 2'd0;
    localparam t_op OP_COUNT = 2'd1;
    localparam t_op OP_AGE   = 2'd2;
    localparam t_op OP_QUERY = 2'd3;

    typedef logic [1:0] t_case;
    localparam t_case CASE_INTERP = 2'd0;
    localparam t_case CASE_BELOW  = 2'd1;
    localparam t_case CASE_ABOVE  = 2'd2;
    localparam t_case CASE_LAST   = 2'd3;

    localparam logic CFG_COLS  = 1'b0;
    localparam logic CFG_METAL = 1'b1;

    // -512.0 in Q16.16 and the fraction clamp of +-2^30
    localparam logic signed [31:0] ABOVE_FILL = -32'sd33554432;
    localparam logic [48:0] FRAC_LIMIT = 49'd1073741824;

endpackage

// ----- rtl/table_row_linear_interpolator_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_row_linear_interpolator_core: piecewise-linear table row lookup
// Stores one Q16.16 table per age point and answers key queries with one
// value per column (interpolated between rows), then metallicity and age.
// ---------------------------------------------------------------------------
// A request carries an opcode in tuser. Table word, row count and age value
// writes are stored as they are accepted. A query is worked out by a sequencer
// around one registered table memory port, one 34-bit restoring divider step
// and one 17x31 multiplier, so the block takes no new request until the last
// result of a query has been taken. A query runs the range checks, a search
// with one memory read per row visited, the fraction division when an
// interpolating pair is found, and per column the interpolation, a copy or
// the fill value, each result held until the sink takes it. Reads of table
// entries never written return whatever the memory holds.
module table_row_linear_interpolator_core
    import trli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] age_sel, [11:4] row_sel, [15:12] column_sel,
    // [47:16] write_value, [79:48] query_key
    input  logic [79:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] column_index, [36:5] column_value, [38:37] case_code,
    // [46:39] next_start_row, [47] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WAIT  = 4'd1;
    localparam logic [3:0] ST_X0    = 4'd2;
    localparam logic [3:0] ST_XN    = 4'd3;
    localparam logic [3:0] ST_SRCH  = 4'd4;
    localparam logic [3:0] ST_XPREV = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_DIVE  = 4'd7;
    localparam logic [3:0] ST_COL   = 4'd8;
    localparam logic [3:0] ST_LOADY = 4'd9;
    localparam logic [3:0] ST_Y0    = 4'd10;
    localparam logic [3:0] ST_Y1    = 4'd11;
    localparam logic [3:0] ST_MUL0  = 4'd12;
    localparam logic [3:0] ST_MUL1  = 4'd13;
    localparam logic [3:0] ST_FIN   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    // Request fields.
    logic [AGE_W-1:0]   w_age;
    logic [7:0]         w_row;
    logic [COL_W-1:0]   w_col;
    logic signed [31:0] w_wv;
    logic signed [31:0] w_key;
    logic               w_acc;

    assign w_age = s_axis_tdata[AGE_W-1:0];
    assign w_row = s_axis_tdata[11:4];
    assign w_col = s_axis_tdata[12 +: COL_W];
    assign w_wv  = s_axis_tdata[47:16];
    assign w_key = s_axis_tdata[79:48];
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    logic [4:0]         r_cols;
    logic signed [31:0] r_metal;

    // Storage. The table is a memory with one write port and one registered read port.
    logic signed [31:0] r_mem [0:(1<<ADDR_W)-1];
    logic [CNT_W-1:0]   r_counts [0:MAX_AGES-1];
    logic signed [31:0] r_ages [0:MAX_AGES-1];
    logic signed [31:0] r_rd;
    logic [ADDR_W-1:0]  r_addr, n_addr;

    // Sequencer state.
    logic [3:0]         r_state, n_state;
    logic [3:0]         r_ret, n_ret;
    logic [AGE_W-1:0]   r_age, n_age;
    logic [7:0]         r_row, n_row;
    logic signed [31:0] r_key, n_key;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [4:0]         r_cc, n_cc;
    logic [ROW_W-1:0]   r_i, n_i;
    logic [4:0]         r_c, n_c;
    t_case              r_code, n_code;
    logic [7:0]         r_next, n_next;
    logic signed [31:0] r_x1, n_x1;
    logic signed [31:0] r_y0, n_y0;
    logic signed [31:0] r_f, n_f;
    // divider: remainder, shifting dividend/quotient, divisor, sign, count
    logic [33:0]        r_rem, n_rem;
    logic [48:0]        r_q, n_q;
    logic [32:0]        r_d, n_d;
    logic               r_neg, n_neg;
    logic [5:0]         r_dcnt, n_dcnt;
    // multiplier: magnitude of dy and accumulator
    logic [32:0]        r_dy, n_dy;
    logic [63:0]        r_acc, n_acc;
    // output register
    logic               r_ovalid, n_ovalid;
    logic [4:0]         r_oidx, n_oidx;
    logic signed [31:0] r_oval, n_oval;
    logic               r_olast, n_olast;

    // Memory and small stores: written only by accepted write requests.
    always_ff @(posedge i_clk) begin
        if (w_acc && s_axis_tuser == OP_WORD && w_row < 8'(MAX_ROWS)) begin
            r_mem[{w_age, w_row[ROW_W-1:0], w_col}] <= w_wv;
        end
        if (w_acc && s_axis_tuser == OP_COUNT) begin
            if (w_wv < 0) begin
                r_counts[w_age] <= '0;
            end else if (w_wv > 32'sd128) begin
                r_counts[w_age] <= CNT_W'(MAX_ROWS);
            end else begin
                r_counts[w_age] <= w_wv[CNT_W-1:0];
            end
        end
        if (w_acc && s_axis_tuser == OP_AGE) begin
            r_ages[w_age] <= w_wv;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= 5'd16;
            r_metal <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_COLS) begin
                r_cols <= i_cfg_data[4:0];
            end else begin
                r_metal <= i_cfg_data;
            end
        end
    end

    // Combinational helpers.
    logic [ROW_W-1:0]   w_nm1;
    logic [ROW_W-1:0]   w_im1;
    logic [CNT_W-1:0]   w_cnt_rd;
    logic [34:0]        w_rtry;
    logic [33:0]        w_rsh;
    logic signed [32:0] w_den;
    logic signed [32:0] w_dnum;
    logic [32:0]        w_dnum_mag;
    logic signed [32:0] w_dy;
    logic [48:0]        w_fmag;
    logic [47:0]        w_prod;
    logic [47:0]        w_qmag;
    logic signed [49:0] w_sum;
    logic [30:0]        w_fabs;

    assign w_nm1    = ROW_W'(r_n - CNT_W'(1));
    assign w_im1    = r_i - ROW_W'(1);
    assign w_cnt_rd = r_counts[w_age];
    assign w_rsh    = {r_rem[32:0], r_q[48]};
    assign w_rtry   = {1'b0, w_rsh} - {2'b00, r_d};
    assign w_den    = 33'(r_x1) - 33'(r_rd);
    assign w_dnum   = 33'(r_key) - 33'(r_rd);
    assign w_dnum_mag = w_dnum[32] ? 33'(-w_dnum) : 33'(w_dnum);
    assign w_dy     = 33'(r_rd) - 33'(r_y0);
    assign w_fmag   = r_q;
    assign w_fabs   = r_f[31] ? 31'(-r_f) : r_f[30:0];
    assign w_prod   = 48'(r_dy[16:0]) * 48'(w_fabs);
    assign w_qmag   = r_acc[63:16];
    assign w_sum    = r_neg ? (50'(r_y0) - 50'(w_qmag)) : (50'(r_y0) + 50'(w_qmag));

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_addr   = r_addr;
        n_age    = r_age;
        n_row    = r_row;
        n_key    = r_key;
        n_n      = r_n;
        n_cc     = r_cc;
        n_i      = r_i;
        n_c      = r_c;
        n_code   = r_code;
        n_next   = r_next;
        n_x1     = r_x1;
        n_y0     = r_y0;
        n_f      = r_f;
        n_rem    = r_rem;
        n_q      = r_q;
        n_d      = r_d;
        n_neg    = r_neg;
        n_dcnt   = r_dcnt;
        n_dy     = r_dy;
        n_acc    = r_acc;
        n_ovalid = r_ovalid;
        n_oidx   = r_oidx;
        n_oval   = r_oval;
        n_olast  = r_olast;

        case (r_state)
            ST_IDLE: begin
                if (w_acc && s_axis_tuser == OP_QUERY) begin
                    n_age  = w_age;
                    n_row  = w_row;
                    n_key  = w_key;
                    n_next = w_row;
                    n_n    = (w_cnt_rd == '0) ? CNT_W'(1) : w_cnt_rd;
                    if (r_cols == 5'd0) begin
                        n_cc = 5'd1;
                    end else if (r_cols > 5'(MAX_COLS)) begin
                        n_cc = 5'(MAX_COLS);
                    end else begin
                        n_cc = r_cols;
                    end
                    n_addr  = {w_age, {ROW_W{1'b0}}, {COL_W{1'b0}}};
                    n_ret   = ST_X0;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = r_ret;
            end
            ST_X0: begin
                n_c = '0;
                if (r_key < r_rd) begin
                    n_code  = CASE_BELOW;
                    n_state = ST_COL;
                end else begin
                    n_addr  = {r_age, w_nm1, {COL_W{1'b0}}};
                    n_ret   = ST_XN;
                    n_state = ST_WAIT;
                end
            end
            ST_XN: begin
                if (r_key > r_rd) begin
                    n_code  = CASE_ABOVE;
                    n_state = ST_COL;
                end else if (r_row >= 8'(r_n)) begin
                    n_code  = CASE_LAST;
                    n_next  = r_row;
                    n_state = ST_COL;
                end else begin
                    n_i     = r_row[ROW_W-1:0];
                    n_addr  = {r_age, r_row[ROW_W-1:0], {COL_W{1'b0}}};
                    n_ret   = ST_SRCH;
                    n_state = ST_WAIT;
                end
            end
            ST_SRCH: begin
                if (r_key < r_rd) begin
                    if (r_i != '0) begin
                        n_x1    = r_rd;
                        n_addr  = {r_age, w_im1, {COL_W{1'b0}}};
                        n_ret   = ST_XPREV;
                        n_state = ST_WAIT;
                    end else begin
                        n_code  = CASE_LAST;
                        n_next  = (r_row > 8'(r_n)) ? r_row : 8'(r_n);
                        n_state = ST_COL;
                    end
                end else if (CNT_W'(r_i) + CNT_W'(1) >= r_n) begin
                    n_code  = CASE_LAST;
                    n_next  = (r_row > 8'(r_n)) ? r_row : 8'(r_n);
                    n_state = ST_COL;
                end else begin
                    n_i     = r_i + ROW_W'(1);
                    n_addr  = {r_age, r_i + ROW_W'(1), {COL_W{1'b0}}};
                    n_ret   = ST_SRCH;
                    n_state = ST_WAIT;
                end
            end
            ST_XPREV: begin
                n_code = CASE_INTERP;
                if (w_den == '0) begin
                    n_f     = '0;
                    n_state = ST_COL;
                end else begin
                    n_d     = w_den[32] ? 33'(-w_den) : 33'(w_den);
                    n_q     = {w_dnum_mag, 16'd0};
                    n_rem   = '0;
                    n_neg   = w_den[32] ^ w_dnum[32];
                    n_dcnt  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // one restoring division step per cycle
                if (!w_rtry[34]) begin
                    n_rem = w_rtry[33:0];
                    n_q   = {r_q[47:0], 1'b1};
                end else begin
                    n_rem = w_rsh;
                    n_q   = {r_q[47:0], 1'b0};
                end
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd48) begin
                    n_state = ST_DIVE;
                end
            end
            ST_DIVE: begin
                if (w_fmag > FRAC_LIMIT) begin
                    n_f = r_neg ? -32'sd1073741824 : 32'sd1073741824;
                end else begin
                    n_f = r_neg ? -32'(w_fmag) : 32'(w_fmag);
                end
                n_state = ST_COL;
            end
            ST_COL: begin
                n_oidx  = r_c;
                n_olast = 1'b0;
                if (r_c == r_cc + 5'd1) begin
                    n_oval   = r_ages[r_age];
                    n_olast  = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ST_OUT;
                end else if (r_c == r_cc) begin
                    n_oval   = r_metal;
                    n_ovalid = 1'b1;
                    n_state  = ST_OUT;
                end else if (r_c == '0) begin
                    // column 0 always reports the key itself
                    n_oval   = r_key;
                    n_ovalid = 1'b1;
                    n_state  = ST_OUT;
                end else begin
                    case (r_code)
                        CASE_ABOVE: begin
                            n_oval   = ABOVE_FILL;
                            n_ovalid = 1'b1;
                            n_state  = ST_OUT;
                        end
                        CASE_BELOW: begin
                            n_addr  = {r_age, {ROW_W{1'b0}}, r_c[COL_W-1:0]};
                            n_ret   = ST_LOADY;
                            n_state = ST_WAIT;
                        end
                        CASE_LAST: begin
                            n_addr  = {r_age, w_nm1, r_c[COL_W-1:0]};
                            n_ret   = ST_LOADY;
                            n_state = ST_WAIT;
                        end
                        default: begin
                            n_addr  = {r_age, w_im1, r_c[COL_W-1:0]};
                            n_ret   = ST_Y0;
                            n_state = ST_WAIT;
                        end
                    endcase
                end
            end
            ST_LOADY: begin
                n_oval   = r_rd;
                n_ovalid = 1'b1;
                n_state  = ST_OUT;
            end
            ST_Y0: begin
                n_y0    = r_rd;
                n_addr  = {r_age, r_i, r_c[COL_W-1:0]};
                n_ret   = ST_Y1;
                n_state = ST_WAIT;
            end
            ST_Y1: begin
                n_dy    = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
                n_neg   = w_dy[32] ^ r_f[31];
                n_state = ST_MUL0;
            end
            ST_MUL0: begin
                n_acc   = 64'(w_prod);
                n_dy    = r_dy >> 17;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                n_acc   = r_acc + (64'(w_prod) << 17);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_sum > 50'sd2147483647) begin
                    n_oval = 32'sh7fffffff;
                end else if (w_sum < -50'sd2147483648) begin
                    n_oval = 32'sh80000000;
                end else begin
                    n_oval = w_sum[31:0];
                end
                n_ovalid = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_c      = r_c + 5'd1;
                    n_state  = r_olast ? ST_IDLE : ST_COL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_ret   <= n_ret;
        r_addr  <= n_addr;
        r_age   <= n_age;
        r_row   <= n_row;
        r_key   <= n_key;
        r_n     <= n_n;
        r_cc    <= n_cc;
        r_i     <= n_i;
        r_c     <= n_c;
        r_code  <= n_code;
        r_next  <= n_next;
        r_x1    <= n_x1;
        r_y0    <= n_y0;
        r_f     <= n_f;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_d     <= n_d;
        r_neg   <= n_neg;
        r_dcnt  <= n_dcnt;
        r_dy    <= n_dy;
        r_acc   <= n_acc;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_next, r_code, r_oval, r_oidx};
    assign m_axis_tlast  = r_olast;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the table row linear interpolator
// Fills age tables with non-decreasing key rows, then sends directed and random
// queries. Each accepted request is run through a local predictor, and every
// result on the output stream is compared field by field with the oldest
// predicted result.
// ---------------------------------------------------------------------------
module testbench;
    import trli_pkg::*;

    typedef struct {
        t_op              op;
        logic [3:0]       age;
        logic [7:0]       row;
        logic [3:0]       col;
        logic signed [31:0] wv;
        logic signed [31:0] key;
    } t_req;

    typedef struct {
        logic [4:0]  idx;
        logic [31:0] val;
        t_case       code;
        logic [7:0]  next;
        logic        last;
    } t_res;

    localparam longint FRAC_CLAMP = 64'sd1073741824;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;

    table_row_linear_interpolator_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: a mirror of the table bank and the two registers.
    int signed   tbl_word [MAX_AGES][MAX_ROWS][MAX_COLS];
    int          tbl_rows [MAX_AGES];
    int signed   tbl_age_val [MAX_AGES];
    logic [4:0]  cols_in_use = 5'd16;
    logic [31:0] metal_val = '0;

    t_req pending_requests[$];
    t_res expected_results[$];
    t_req active_req;
    int   error_count = 0;
    int   cycle_count = 0;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Applies one accepted request to the mirror and, for a query, queues
    // the results it must produce.
    task automatic apply_request(input t_req r);
        int     n, cc, i;
        longint key, x0, den, frac, y0, dy, acc;
        int signed vals [MAX_COLS];
        t_case  code;
        logic [7:0] next;
        bit     hit;
        t_res   e;
        case (r.op)
            OP_WORD: begin
                if (r.row < MAX_ROWS) tbl_word[r.age][r.row][r.col] = r.wv;
            end
            OP_COUNT: begin
                tbl_rows[r.age] = (r.wv < 0) ? 0 : ((r.wv > MAX_ROWS) ? MAX_ROWS : r.wv);
            end
            OP_AGE: begin
                tbl_age_val[r.age] = r.wv;
            end
            default: begin
                n = (tbl_rows[r.age] < 1) ? 1 : tbl_rows[r.age];
                cc = (cols_in_use < 1) ? 1 : ((cols_in_use > MAX_COLS) ? MAX_COLS : cols_in_use);
                key = r.key;
                next = r.row;
                hit = 0;
                if (key < tbl_word[r.age][0][0]) begin
                    code = CASE_BELOW;
                    for (int c = 0; c < cc; c++) vals[c] = tbl_word[r.age][0][c];
                end else if (key > tbl_word[r.age][n-1][0]) begin
                    code = CASE_ABOVE;
                    for (int c = 0; c < cc; c++) vals[c] = ABOVE_FILL;
                end else begin
                    for (i = r.row; i < n; i++) begin
                        if (key < tbl_word[r.age][i][0]) begin
                            hit = 1;
                            break;
                        end
                    end
                    if (hit && i >= 1) begin
                        code = CASE_INTERP;
                        x0 = tbl_word[r.age][i-1][0];
                        den = longint'(tbl_word[r.age][i][0]) - x0;
                        frac = 0;
                        if (den != 0) begin
                            frac = ((key - x0) * 65536) / den;
                            if (frac > FRAC_CLAMP) frac = FRAC_CLAMP;
                            if (frac < -FRAC_CLAMP) frac = -FRAC_CLAMP;
                        end
                        for (int c = 0; c < cc; c++) begin
                            y0 = tbl_word[r.age][i-1][c];
                            dy = longint'(tbl_word[r.age][i][c]) - y0;
                            acc = y0 + (dy * frac) / 65536;
                            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                            vals[c] = int'(acc);
                        end
                    end else begin
                        code = CASE_LAST;
                        next = (r.row > n) ? r.row : n[7:0];
                        for (int c = 0; c < cc; c++) vals[c] = tbl_word[r.age][n-1][c];
                    end
                end
                vals[0] = r.key;
                for (int c = 0; c < cc + 2; c++) begin
                    e.idx = c[4:0];
                    e.val = (c < cc) ? vals[c] : ((c == cc) ? metal_val : tbl_age_val[r.age]);
                    e.code = code;
                    e.next = next;
                    e.last = (c == cc + 1);
                    expected_results.push_back(e);
                end
            end
        endcase
    endtask

    // Request driver: each side holds back with a chance of 8 in 100, except
    // inside one quiet window where it never does.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) apply_request(active_req);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() > 0 &&
                    !((cycle_count < 3000 || cycle_count > 9000) &&
                      $urandom_range(99) < 8)) begin
                    active_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {active_req.key, active_req.wv, active_req.col,
                                     active_req.row, active_req.age};
                    s_axis_tuser <= active_req.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (cycle_count >= 3000 && cycle_count <= 9000) ||
                             ($urandom_range(99) >= 8);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
                end else begin
                    e = expected_results.pop_front();
                    if (m_axis_tdata[4:0] !== e.idx)
                        report_mismatch($sformatf("column_index %0d, want %0d",
                                                  m_axis_tdata[4:0], e.idx));
                    if (m_axis_tdata[36:5] !== e.val)
                        report_mismatch($sformatf("column_value %h, want %h (col %0d)",
                                                  m_axis_tdata[36:5], e.val, e.idx));
                    if (m_axis_tdata[38:37] !== e.code)
                        report_mismatch($sformatf("case_code %0d, want %0d",
                                                  m_axis_tdata[38:37], e.code));
                    if (m_axis_tdata[46:39] !== e.next)
                        report_mismatch($sformatf("next_start_row %0d, want %0d",
                                                  m_axis_tdata[46:39], e.next));
                    if (m_axis_tlast !== e.last)
                        report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
                end
            end
        end
    end

    // Generator bookkeeping: rows fully written, effective row count, keys.
    int          gen_rows [MAX_AGES];
    int          gen_n [MAX_AGES];
    int signed   gen_key [MAX_AGES][MAX_ROWS];
    bit          gen_ready [MAX_AGES];

    task automatic send(input t_op op, input int age, input int row, input int col,
                        input int signed wv, input int signed key);
        t_req r;
        r.op = op;
        r.age = age[3:0];
        r.row = row[7:0];
        r.col = col[3:0];
        r.wv = wv;
        r.key = key;
        pending_requests.push_back(r);
    endtask

    // Writes every word of rows 0..n-1 with non-decreasing keys, plus count and age.
    task automatic build_table(input int age, input int n);
        longint k;
        k = -longint'($urandom_range(32'h4000_0000));
        for (int r = 0; r < n; r++) begin
            if (r > 0 && $urandom_range(7) != 0) k += $urandom_range(32'h0100_0000);
            gen_key[age][r] = int'(k);
            for (int c = 0; c < MAX_COLS; c++)
                send(OP_WORD, age, r, c, (c == 0) ? int'(k) : int'($urandom), $urandom);
        end
        gen_rows[age] = n;
        gen_n[age] = n;
        gen_ready[age] = 1;
        send(OP_COUNT, age, $urandom_range(MAX_ROWS), $urandom_range(15), n, $urandom);
        send(OP_AGE, age, $urandom_range(MAX_ROWS), $urandom_range(15), $urandom, $urandom);
    endtask

    task automatic random_query(input int age);
        int     n, a, b;
        longint k;
        int     row;
        n = gen_n[age];
        a = $urandom_range(n - 1);
        b = (a + 1 < n) ? a + 1 : a;
        case ($urandom_range(5))
            0: k = longint'(gen_key[age][0]) - $urandom_range(1, 32'h00ff_ffff);
            1: k = longint'(gen_key[age][n-1]) + $urandom_range(1, 32'h00ff_ffff);
            2: k = gen_key[age][a];
            3: k = longint'(gen_key[age][a]) +
                   ((longint'(gen_key[age][b]) - gen_key[age][a]) * $urandom_range(255)) / 256;
            default: k = int'($urandom);
        endcase
        if (k > 64'sd2147483647) k = 64'sd2147483647;
        if (k < -64'sd2147483648) k = -64'sd2147483648;
        case ($urandom_range(7))
            0, 1, 2: row = 0;
            3, 4:    row = $urandom_range(n - 1);
            5, 6:    row = $urandom_range(n + 2);
            default: row = MAX_ROWS;
        endcase
        send(OP_QUERY, age, row, $urandom_range(15), $urandom, int'(k));
    endtask

    task automatic random_traffic(input int count);
        int age, r, c, v;
        for (int j = 0; j < count; j++) begin
            do age = $urandom_range(MAX_AGES - 1); while (!gen_ready[age]);
            r = $urandom_range(99);
            if (r < 60) begin
                random_query(age);
            end else if (r < 75) begin
                // Overwrite a word already written; keys only now and then.
                r = $urandom_range(gen_rows[age] - 1);
                c = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, MAX_COLS - 1);
                v = $urandom;
                if (c == 0) gen_key[age][r] = v;
                send(OP_WORD, age, r, c, v, $urandom);
            end else if (r < 82) begin
                v = $urandom;
                send(OP_COUNT, age, $urandom_range(MAX_ROWS), $urandom_range(15), v, $urandom);
                v = (v < 0) ? 0 : ((v > MAX_ROWS) ? MAX_ROWS : v);
                if (v > gen_rows[age]) begin
                    v = $urandom_range(gen_rows[age]);
                    send(OP_COUNT, age, 0, 0, v, $urandom);
                end
                gen_n[age] = (v < 1) ? 1 : v;
            end else if (r < 88) begin
                send(OP_AGE, age, $urandom_range(MAX_ROWS), $urandom_range(15),
                     $urandom, $urandom);
            end else if (r < 95) begin
                // Row past the table: the write is dropped.
                send(OP_WORD, age, MAX_ROWS, $urandom_range(15), $urandom, $urandom);
            end else begin
                random_query(age);
            end
        end
    endtask

    // Waits until every request is taken and every result has come back,
    // then lets the block settle before a register is touched.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_COLS) cols_in_use = data[4:0];
        else metal_val = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_COLS, 32'd16);
        write_reg(CFG_METAL, 32'h0001_8000);

        // Age 0 keys 0, 10, 10, 20: the repeated key gives a zero-width pair.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < MAX_COLS; c++)
                send(OP_WORD, 0, r, c,
                     (c == 0) ? ((r == 0) ? 0 : (r == 3) ? 20 << 16 : 10 << 16)
                              : int'($urandom), 0);
        send(OP_COUNT, 0, 0, 0, 32'h7fff_ffff, 0);    // saturates to the maximum
        send(OP_COUNT, 0, 0, 0, 4, 0);
        send(OP_AGE, 0, 0, 0, 32'h8000_0000, 0);
        send(OP_WORD, 0, MAX_ROWS, 15, 32'hdead_beef, 0);   // dropped
        send(OP_QUERY, 0, 0, 0, 0, 32'h8000_0000);     // below range
        send(OP_QUERY, 0, 0, 0, 0, 32'h7fff_ffff);     // above range
        send(OP_QUERY, 0, 0, 0, 0, 0);                 // exactly row 0
        send(OP_QUERY, 0, 0, 0, 0, 3 << 15);           // between rows 0 and 1
        send(OP_QUERY, 0, 2, 0, 0, 5 << 16);           // zero-width pair
        send(OP_QUERY, 0, 3, 0, 0, 2 << 16);           // start past key, extrapolate
        send(OP_QUERY, 0, 0, 0, 0, 20 << 16);          // runs off the end
        send(OP_QUERY, 0, 128, 0, 0, 15 << 16);        // start row beyond the table
        send(OP_QUERY, 0, 100, 0, 0, 12 << 16);
        send(OP_COUNT, 0, 0, 0, 32'hffff_fff0, 0);     // negative count, one row used
        send(OP_QUERY, 0, 0, 0, 0, 0);
        send(OP_QUERY, 0, 0, 0, 0, -1);
        send(OP_COUNT, 0, 0, 0, 4, 0);
        for (int r = 0; r < 4; r++) gen_key[0][r] = (r == 0) ? 0 : (r == 3) ? 20 << 16 : 10 << 16;
        gen_rows[0] = 4;
        gen_n[0] = 4;
        gen_ready[0] = 1;
        build_table($urandom_range(1, 15), $urandom_range(1, 6));
        random_traffic(40);
        wait_drained();

        // Further register settings, the extremes among them.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_COLS, 32'd1);
                    write_reg(CFG_METAL, 32'h7fff_ffff);
                end
                1: begin
                    write_reg(CFG_COLS, 32'd16);
                    write_reg(CFG_METAL, 32'h8000_0000);
                end
                2: begin
                    write_reg(CFG_COLS, 32'd7);
                    write_reg(CFG_METAL, $urandom);
                end
                default: begin
                    write_reg(CFG_COLS, $urandom_range(1, 16));
                    write_reg(CFG_METAL, $urandom);
                end
            endcase
            build_table($urandom_range(15), $urandom_range(1, 4));
            random_traffic(25);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/trli_pkg.sv
rtl/table_row_linear_interpolator_core.sv
tb/sv/testbench.sv
